// ===== hw/rtl/gbdc_pkg.sv =====
package gbdc_pkg;

	localparam int RAW_W    = 16;
	localparam int RATE_W   = 29;
	localparam int RPC_W    = 12;
	localparam int CNT_W    = 9;
	localparam int MULT_W   = 8;
	localparam int SUM_W    = 24;
	localparam int SQ_W     = 40;
	localparam int BIAS_W   = 24;
	localparam int SPREAD_W = 24;
	localparam int CFG_W    = 12;
	localparam int IDX_W    = 2;

	// Width of the shared divide numerator, set by the square sum shifted by 16.
	localparam int NUM_W    = 55;
	localparam int VAR_W    = 48;
	localparam int STEP_W   = 6;

	localparam logic [IDX_W-1:0] REG_RATE_PER_COUNT      = 2'd0;
	localparam logic [IDX_W-1:0] REG_CALIBRATION_SAMPLES = 2'd1;
	localparam logic [IDX_W-1:0] REG_THRESHOLD_MULTIPLE  = 2'd2;

	localparam logic [RPC_W-1:0]  RPC_RESET  = 12'd500;
	localparam logic [7:0]        CSMP_RESET = 8'd50;
	localparam logic [MULT_W-1:0] MULT_RESET = 8'd0;

	localparam logic OP_MEASURE   = 1'b0;
	localparam logic OP_CALIBRATE = 1'b1;

	typedef struct packed {
		logic load_raw;
		logic acc;
		logic ld_divb;
		logic ld_divv;
		logic div_step;
		logic bsq;
		logic ld_sqrt;
		logic sqrt_step;
		logic finish;
		logic meas;
	} lane_ctl_t;

endpackage

// ===== hw/rtl/gbdc_lane.sv =====
module gbdc_lane (
	input  logic                            clk,
	input  logic                            arst_n,
	input  gbdc_pkg::lane_ctl_t             ctl,
	input  logic signed [gbdc_pkg::RAW_W-1:0] raw,
	input  logic [gbdc_pkg::CNT_W-1:0]      cnt,
	input  logic [gbdc_pkg::RPC_W-1:0]      rpc,
	input  logic [gbdc_pkg::MULT_W-1:0]     mult,
	input  logic                            cal,
	output logic signed [gbdc_pkg::RATE_W-1:0] rate
);
	import gbdc_pkg::*;

	logic signed [RAW_W-1:0]    raw_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [SQ_W-1:0]            sq_q;
	logic signed [BIAS_W-1:0]   bias_q;
	logic [SPREAD_W-1:0]        spread_q;
	logic                       sgn_q;
	logic [NUM_W-1:0]           num_q;
	logic [CNT_W-1:0]           rem_q;
	logic [VAR_W-1:0]           bsq_q;
	logic [VAR_W-1:0]           sqv_q;
	logic [SPREAD_W+2:0]        srem_q;
	logic [SPREAD_W-1:0]        root_q;
	logic signed [38:0]         p_s1;
	logic [31:0]                thr_s1;

	logic signed [31:0]         sqr;
	logic [SUM_W-1:0]           sum_mag;
	logic [CNT_W:0]             dr;
	logic                       dge;
	logic [BIAS_W-1:0]          qb;
	logic signed [47:0]         bprod;
	logic [SPREAD_W+2:0]        sr2;
	logic [SPREAD_W+2:0]        trial;
	logic signed [25:0]         dval;
	logic [37:0]                pmag;
	logic [30:0]                pq;
	logic [RATE_W-1:0]          smag;
	logic signed [RATE_W-1:0]   sat;
	logic [39:0]                thr;

	assign sqr     = 32'(raw_q) * 32'(raw_q);
	assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign dr      = {rem_q, num_q[NUM_W-1]};
	assign dge     = dr >= {1'b0, cnt};
	assign qb      = num_q[BIAS_W-1:0];
	assign bprod   = 48'(bias_q) * 48'(bias_q);
	assign sr2     = {srem_q[SPREAD_W:0], sqv_q[VAR_W-1 -: 2]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign dval    = (26'(raw_q) <<< 8) - (cal ? 26'(bias_q) : 26'sd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			sq_q     <= '0;
			bias_q   <= '0;
			spread_q <= '0;
		end else begin
			if (ctl.acc) begin
				sum_q <= sum_q + SUM_W'(raw_q);
				sq_q  <= sq_q + SQ_W'(unsigned'(sqr));
			end
			if (ctl.ld_divv)
				bias_q <= sgn_q ? BIAS_W'(-qb) : qb;
			if (ctl.finish) begin
				spread_q <= root_q;
				sum_q    <= '0;
				sq_q     <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_raw)
			raw_q <= raw;
		if (ctl.ld_divb) begin
			sgn_q <= sum_q[SUM_W-1];
			num_q <= NUM_W'({sum_mag, 8'b0}) + NUM_W'(cnt >> 1);
			rem_q <= '0;
		end
		if (ctl.ld_divv) begin
			num_q <= {sq_q[38:0], 16'b0};
			rem_q <= '0;
		end
		if (ctl.div_step) begin
			rem_q <= dge ? CNT_W'(dr - {1'b0, cnt}) : dr[CNT_W-1:0];
			num_q <= {num_q[NUM_W-2:0], dge};
		end
		if (ctl.bsq)
			bsq_q <= unsigned'(bprod);
		if (ctl.ld_sqrt) begin
			sqv_q  <= (VAR_W'(num_q) > bsq_q) ? VAR_W'(num_q) - bsq_q : '0;
			srem_q <= '0;
			root_q <= '0;
		end
		if (ctl.sqrt_step) begin
			sqv_q <= {sqv_q[VAR_W-3:0], 2'b00};
			if (sr2 >= trial) begin
				srem_q <= sr2 - trial;
				root_q <= {root_q[SPREAD_W-2:0], 1'b1};
			end else begin
				srem_q <= sr2;
				root_q <= {root_q[SPREAD_W-2:0], 1'b0};
			end
		end
		if (ctl.meas) begin
			p_s1   <= 39'(dval) * 39'(signed'({1'b0, rpc}));
			thr_s1 <= 32'(spread_q) * 32'(mult);
		end
	end

	// Round half away from zero on the magnitude, saturate to 29 bits, then apply the deadband.
	always_comb begin
		pmag = p_s1[38] ? 38'(-p_s1) : 38'(p_s1);
		pq   = 31'((39'(pmag) + 39'd128) >> 8);
		if (!p_s1[38]) begin
			smag = (pq > 31'd268435455) ? 29'd268435455 : pq[RATE_W-1:0];
			sat  = signed'(smag);
		end else begin
			smag = (pq > 31'd268435456) ? 29'h1000_0000 : pq[RATE_W-1:0];
			sat  = signed'(RATE_W'(-smag));
		end
		thr  = {thr_s1, 8'b0};
		rate = (mult != '0 && 40'(smag) < thr) ? '0 : sat;
	end

endmodule

// ===== hw/rtl/gyro_bias_deadband_calibrator_core.sv =====
// Three-axis gyro calibrator. A calibration beat (op = 1) adds its axes into per-axis
// sums; the beat that completes the configured count also runs the bias and spread
// computation, a 55-step bit-serial divide twice, a squaring and a 24-step square
// root, all three axes in parallel. A measurement beat (op = 0) passes through the
// lane multipliers and gives one result beat with bias removed (once calibrated),
// scaled to Q.16 dps and deadbanded. One beat is worked on at a time; the result
// register lets the next beat enter while a result still waits. The user must write
// configuration only while the block is idle; the block itself does not enforce it.
module gyro_bias_deadband_calibrator_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [gbdc_pkg::IDX_W-1:0]             cfg_index,
	input  logic [gbdc_pkg::CFG_W-1:0]             cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   op,
	input  logic signed [gbdc_pkg::RAW_W-1:0]      raw_x,
	input  logic signed [gbdc_pkg::RAW_W-1:0]      raw_y,
	input  logic signed [gbdc_pkg::RAW_W-1:0]      raw_z,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [gbdc_pkg::RATE_W-1:0]     rate_x,
	output logic signed [gbdc_pkg::RATE_W-1:0]     rate_y,
	output logic signed [gbdc_pkg::RATE_W-1:0]     rate_z,
	output logic                                   bias_applied
);
	import gbdc_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_ACC   = 4'd1;
	localparam logic [3:0] ST_DIVB  = 4'd2;
	localparam logic [3:0] ST_DIVV  = 4'd3;
	localparam logic [3:0] ST_BSQ   = 4'd4;
	localparam logic [3:0] ST_LSQ   = 4'd5;
	localparam logic [3:0] ST_SQRT  = 4'd6;
	localparam logic [3:0] ST_FIN   = 4'd7;
	localparam logic [3:0] ST_MEAS1 = 4'd8;
	localparam logic [3:0] ST_MEAS2 = 4'd9;

	logic [3:0]          state_q;
	logic [RPC_W-1:0]    rpc_q;
	logic [7:0]          csmp_q;
	logic [MULT_W-1:0]   mult_q;
	logic [7:0]          cal_cnt_q;
	logic                is_cal_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [STEP_W-1:0]   step_q;
	logic                out_valid_q;

	lane_ctl_t           ctl;
	logic                in_acc;
	logic                out_free;
	logic [CNT_W-1:0]    taken;
	logic [CNT_W-1:0]    need;
	logic signed [RAW_W-1:0]  raw_in [3];
	logic signed [RATE_W-1:0] lane_rate [3];

	assign in_stall  = state_q != ST_IDLE;
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign taken     = CNT_W'(cal_cnt_q) + CNT_W'(1);
	assign need      = (csmp_q == '0) ? CNT_W'(256) : CNT_W'(csmp_q);

	assign raw_in[0] = raw_x;
	assign raw_in[1] = raw_y;
	assign raw_in[2] = raw_z;

	always_comb begin
		ctl           = '0;
		ctl.load_raw  = in_acc;
		ctl.acc       = state_q == ST_ACC;
		// Each divide pass loads its operands at step 0 and then runs 55 steps.
		ctl.ld_divb   = state_q == ST_DIVB && step_q == '0;
		ctl.ld_divv   = state_q == ST_DIVV && step_q == '0;
		ctl.div_step  = (state_q == ST_DIVB || state_q == ST_DIVV) && step_q != '0;
		ctl.bsq       = state_q == ST_BSQ;
		ctl.ld_sqrt   = state_q == ST_LSQ;
		ctl.sqrt_step = state_q == ST_SQRT;
		ctl.finish    = state_q == ST_FIN;
		ctl.meas      = state_q == ST_MEAS1;
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		gbdc_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.raw    (raw_in[i]),
			.cnt    (cnt_q),
			.rpc    (rpc_q),
			.mult   (mult_q),
			.cal    (is_cal_q),
			.rate   (lane_rate[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpc_q  <= RPC_RESET;
			csmp_q <= CSMP_RESET;
			mult_q <= MULT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RATE_PER_COUNT:      rpc_q  <= cfg_data[RPC_W-1:0];
				REG_CALIBRATION_SAMPLES: csmp_q <= cfg_data[7:0];
				REG_THRESHOLD_MULTIPLE:  mult_q <= cfg_data[MULT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cal_cnt_q   <= '0;
			is_cal_q    <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc)
						state_q <= (op == OP_CALIBRATE) ? ST_ACC : ST_MEAS1;
				end
				ST_ACC: begin
					cal_cnt_q <= taken[7:0];
					step_q    <= '0;
					state_q   <= (taken >= need) ? ST_DIVB : ST_IDLE;
				end
				ST_DIVB, ST_DIVV: begin
					if (step_q == STEP_W'(NUM_W)) begin
						step_q  <= '0;
						state_q <= (state_q == ST_DIVB) ? ST_DIVV : ST_BSQ;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_BSQ:  state_q <= ST_LSQ;
				ST_LSQ: begin
					step_q  <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (step_q == STEP_W'(SPREAD_W - 1))
						state_q <= ST_FIN;
					else
						step_q <= step_q + STEP_W'(1);
				end
				ST_FIN: begin
					cal_cnt_q <= '0;
					is_cal_q  <= 1'b1;
					state_q   <= ST_IDLE;
				end
				ST_MEAS1: state_q <= ST_MEAS2;
				ST_MEAS2: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ACC)
			cnt_q <= taken;
		if (state_q == ST_MEAS2 && out_free) begin
			rate_x       <= lane_rate[0];
			rate_y       <= lane_rate[1];
			rate_z       <= lane_rate[2];
			bias_applied <= is_cal_q;
		end
	end

	a_meas_path: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && op == OP_MEASURE |=> state_q == ST_MEAS1)
		else $error("measurement beat did not enter the datapath");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MEAS2 && out_free |=> out_valid_q)
		else $error("result not posted");

	a_cal_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |=> is_cal_q && cal_cnt_q == '0)
		else $error("calibration finish did not update state");

	a_no_result_cal: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ACC && !out_valid_q |=> !out_valid_q)
		else $error("calibration beat produced a result");

endmodule

// ===== verif/gbdc_checker.sv =====
`timescale 1ns / 1ps

module gbdc_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [gbdc_pkg::IDX_W-1:0]             cfg_index,
	input  logic [gbdc_pkg::CFG_W-1:0]             cfg_data,
	input  logic                                   in_valid,
	input  logic                                   in_stall,
	input  logic                                   op,
	input  logic signed [gbdc_pkg::RAW_W-1:0]      raw_x,
	input  logic signed [gbdc_pkg::RAW_W-1:0]      raw_y,
	input  logic signed [gbdc_pkg::RAW_W-1:0]      raw_z,
	input  logic                                   out_valid,
	input  logic                                   out_stall,
	input  logic signed [gbdc_pkg::RATE_W-1:0]     rate_x,
	input  logic signed [gbdc_pkg::RATE_W-1:0]     rate_y,
	input  logic signed [gbdc_pkg::RATE_W-1:0]     rate_z,
	input  logic                                   bias_applied,
	output int                                     fail_count,
	output int                                     pending
);
	import gbdc_pkg::*;

	typedef struct packed {
		logic [RATE_W-1:0] rx;
		logic [RATE_W-1:0] ry;
		logic [RATE_W-1:0] rz;
		logic              applied;
	} rate_beat_t;

	rate_beat_t expected_rates[$];

	logic [RPC_W-1:0] m_rpc;
	logic [7:0]       m_samples;
	logic [7:0]       m_mult;
	int unsigned      m_count;
	longint           m_sum[3];
	longint unsigned  m_sqsum[3];
	longint           m_bias[3];
	longint unsigned  m_spread[3];
	bit               m_cal;

	assign pending = expected_rates.size();

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	task automatic close_calibration(longint unsigned n);
		longint s, bias;
		longint unsigned mag, q, msq, bsq;
		for (int a = 0; a < 3; a++) begin
			s = m_sum[a];
			mag = (s < 0 ? -s : s) << 8;
			q = (mag + n / 2) / n;
			bias = s < 0 ? -longint'(q) : longint'(q);
			msq = (m_sqsum[a] << 16) / n;
			bsq = bias * bias;
			m_bias[a] = bias;
			m_spread[a] = int_sqrt(msq > bsq ? msq - bsq : 0);
			m_sum[a] = 0;
			m_sqsum[a] = 0;
		end
		m_count = 0;
		m_cal = 1;
	endtask

	task automatic take_sample(logic cal, logic signed [RAW_W-1:0] rw[3]);
		longint d, p, r;
		longint unsigned mag, q, thr, need, taken;
		logic [RATE_W-1:0] res[3];
		if (cal == OP_CALIBRATE) begin
			taken = m_count + 1;
			need = m_samples == 0 ? 256 : m_samples;
			for (int a = 0; a < 3; a++) begin
				m_sum[a] += rw[a];
				m_sqsum[a] += longint'(rw[a]) * longint'(rw[a]);
			end
			m_count = taken & 8'hFF;
			if (taken >= need) close_calibration(taken);
			return;
		end
		for (int a = 0; a < 3; a++) begin
			d = longint'(rw[a]) * 256;
			if (m_cal) d -= m_bias[a];
			p = d * longint'(m_rpc);
			mag = p < 0 ? -p : p;
			q = (mag + 128) >> 8;
			r = p < 0 ? -longint'(q) : longint'(q);
			if (r > 268435455) r = 268435455;
			if (r < -268435456) r = -268435456;
			if (m_mult != 0) begin
				thr = (m_spread[a] * m_mult) << 8;
				if ((r < 0 ? -r : r) < thr) r = 0;
			end
			res[a] = r[RATE_W-1:0];
		end
		expected_rates.push_back('{res[0], res[1], res[2], m_cal});
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic signed [RAW_W-1:0] rw[3];
		rate_beat_t e;
		if (!arst_n) begin
			m_rpc = RPC_RESET;
			m_samples = CSMP_RESET;
			m_mult = MULT_RESET;
			m_count = 0;
			m_cal = 0;
			for (int a = 0; a < 3; a++) begin
				m_sum[a] = 0; m_sqsum[a] = 0; m_bias[a] = 0; m_spread[a] = 0;
			end
			expected_rates.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_RATE_PER_COUNT:      m_rpc = cfg_data[RPC_W-1:0];
					REG_CALIBRATION_SAMPLES: m_samples = cfg_data[7:0];
					REG_THRESHOLD_MULTIPLE:  m_mult = cfg_data[7:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_rates.size() == 0) begin
					$error("result beat with nothing expected");
					fail_count++;
				end else begin
					e = expected_rates.pop_front();
					if (rate_x !== e.rx) begin
						$error("rate_x expected %0d got %0d", $signed(e.rx), rate_x);
						fail_count++;
					end
					if (rate_y !== e.ry) begin
						$error("rate_y expected %0d got %0d", $signed(e.ry), rate_y);
						fail_count++;
					end
					if (rate_z !== e.rz) begin
						$error("rate_z expected %0d got %0d", $signed(e.rz), rate_z);
						fail_count++;
					end
					if (bias_applied !== e.applied) begin
						$error("bias_applied expected %0d got %0d", e.applied, bias_applied);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				rw[0] = raw_x; rw[1] = raw_y; rw[2] = raw_z;
				take_sample(op, rw);
			end
		end
	end
endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import gbdc_pkg::*;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [IDX_W-1:0]         cfg_index;
	logic [CFG_W-1:0]         cfg_data;
	logic                     in_valid;
	logic                     in_stall;
	logic                     op;
	logic signed [RAW_W-1:0]  raw_x, raw_y, raw_z;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [RATE_W-1:0] rate_x, rate_y, rate_z;
	logic                     bias_applied;
	int                       fail_count;
	int                       pending;
	int                       stall_mode;

	gyro_bias_deadband_calibrator_core u_top (.*);
	gbdc_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

	// The receiver alternates between no stall, light stall and heavy stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 0;
			stall_mode <= 0;
		end else begin
			if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
			case (stall_mode)
				0: out_stall <= 0;
				1: out_stall <= $urandom_range(0, 3) == 0;
				default: out_stall <= $urandom_range(0, 3) != 0;
			endcase
		end
	end

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// A calibration beat can still be in its long finishing pass.
		repeat (200) @(posedge clk);
	endtask

	task automatic send(logic o, logic signed [RAW_W-1:0] x, y, z);
		in_valid <= 1;
		op <= o;
		raw_x <= x;
		raw_y <= y;
		raw_z <= z;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic idle(int n);
		in_valid <= 0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic signed [RAW_W-1:0] rand_raw(int spread_sel, int center);
		case (spread_sel)
			0: return RAW_W'($urandom);
			1: return RAW_W'(center + $signed($urandom_range(0, 40)) - 20);
			default: return RAW_W'(center + $signed($urandom_range(0, 600)) - 300);
		endcase
	endfunction

	task automatic random_phase(int items);
		int burst, sel, cx, cy, cz;
		sel = $urandom_range(0, 2);
		cx = $signed($urandom_range(0, 4000)) - 2000;
		cy = $signed($urandom_range(0, 4000)) - 2000;
		cz = $signed($urandom_range(0, 4000)) - 2000;
		burst = $urandom_range(1, 12);
		for (int i = 0; i < items; i++) begin
			if (burst == 0) begin
				idle($urandom_range(1, 6));
				burst = $urandom_range(1, 12);
			end
			burst--;
			send($urandom_range(0, 2) == 0, rand_raw(sel, cx), rand_raw(sel, cy),
				rand_raw(sel, cz));
			if (i == items / 2) begin
				in_valid <= 0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
		end
		in_valid <= 0;
	endtask

	initial begin
		logic signed [RAW_W-1:0] ext[4];
		arst_n = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 0;
		op = OP_MEASURE;
		raw_x = 0;
		raw_y = 0;
		raw_z = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Measurements and deadband before any calibration.
		ext = '{16'sh7FFF, -16'sh8000, 16'sh0000, 16'shFFFF};
		write_reg(REG_RATE_PER_COUNT, 12'hFFF);
		write_reg(REG_THRESHOLD_MULTIPLE, 12'd255);
		foreach (ext[i]) send(OP_MEASURE, ext[i], ext[(i+1)%4], ext[(i+2)%4]);
		idle(1);
		drain();
		// Short calibration on extremes, then measure with the new bias.
		write_reg(REG_CALIBRATION_SAMPLES, 12'd3);
		write_reg(REG_THRESHOLD_MULTIPLE, 12'd1);
		send(OP_CALIBRATE, 16'sh7FFF, -16'sh8000, 16'sh0005);
		send(OP_MEASURE, 16'sh0001, 16'sh0002, 16'sh0003);
		send(OP_CALIBRATE, 16'sh7FFF, -16'sh8000, -16'sh0007);
		send(OP_CALIBRATE, -16'sh8000, 16'sh7FFF, 16'sh0002);
		foreach (ext[i]) send(OP_MEASURE, ext[i], ext[(i+3)%4], ext[(i+1)%4]);
		idle(1);
		drain();
		// Count lowered mid-run, then a count of zero meaning 256.
		write_reg(REG_CALIBRATION_SAMPLES, 12'd10);
		repeat (4) send(OP_CALIBRATE, 16'sd100, -16'sd50, 16'sd3);
		idle(1);
		drain();
		write_reg(REG_CALIBRATION_SAMPLES, 12'd2);
		send(OP_CALIBRATE, 16'sd90, -16'sd40, 16'sd1);
		send(OP_MEASURE, 16'sd95, -16'sd45, 16'sd2);
		idle(1);
		drain();
		write_reg(REG_CALIBRATION_SAMPLES, 12'd0);
		write_reg(REG_RATE_PER_COUNT, 12'd0);
		write_reg(REG_THRESHOLD_MULTIPLE, 12'd0);
		repeat (256) send(OP_CALIBRATE, rand_raw(0, 0), rand_raw(0, 0), rand_raw(0, 0));
		send(OP_MEASURE, 16'sd7, -16'sd7, 16'sd0);
		idle(1);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_RATE_PER_COUNT, ph == 0 ? 12'd4095 : (ph == 1 ? 12'd1 :
				12'($urandom_range(0, 4095))));
			write_reg(REG_CALIBRATION_SAMPLES, ph == 2 ? 12'd255 : (ph == 3 ? 12'd1 :
				12'($urandom_range(1, 40))));
			write_reg(REG_THRESHOLD_MULTIPLE, ph == 4 ? 12'd0 :
				12'($urandom_range(0, 8)));
			random_phase(ph == 2 ? 400 : 200);
			drain();
		end

		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
